### rtl/core/vfdv_pkg.sv
// ---------------------------------------------------------------------------
// vfdv_pkg
// Shared types and constants for the finite-difference velocity block.
// ---------------------------------------------------------------------------
`default_nettype none

package vfdv_pkg;

  localparam int FIELD_W          = 32;  // displacement, velocity and time width
  localparam int IV_W             = 16;  // frame interval register width
  localparam int NUM_AXES_MAX     = 3;   // axis fields carried on the ports
  localparam int AXIS_IDX_W       = 2;   // index into the axis fields
  localparam int AXES_DEF         = 3;
  localparam int SAMPLE_WIDTH_DEF = 32;

  // Divider operand widths: magnitude of a 33-bit difference over up to 2*interval
  localparam int DIVIDEND_W = FIELD_W + 1;
  localparam int DIVISOR_W  = IV_W + 1;

  localparam logic [IV_W-1:0] IV_RESET = IV_W'(1);

  // Frame history codes
  localparam logic [1:0] PH_EMPTY = 2'd0;
  localparam logic [1:0] PH_ONE   = 2'd1;
  localparam logic [1:0] PH_TWO   = 2'd2;

  typedef struct packed {
    logic signed [FIELD_W-1:0] disp_x;
    logic signed [FIELD_W-1:0] disp_y;
    logic signed [FIELD_W-1:0] disp_z;
    logic        [FIELD_W-1:0] frame_time;
    logic                      final_frame;
  } in_item_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] vel_x;
    logic signed [FIELD_W-1:0] vel_y;
    logic signed [FIELD_W-1:0] vel_z;
    logic        [FIELD_W-1:0] stamp;
    logic                      saturated;
    logic                      run_end;
  } out_item_t;

endpackage

`default_nettype wire

### rtl/core/vector_finite_difference_velocity.sv
// ---------------------------------------------------------------------------
// vector_finite_difference_velocity
// Three-point finite-difference velocity of a 3-axis Q16.16 displacement stream.
// ---------------------------------------------------------------------------
//  channel | handshake           | payload            | direction
//  in_     | in_valid / in_stall | vfdv_pkg::in_item_t | frame in
//  out_    | out_valid/out_stall | vfdv_pkg::out_item_t| velocity out
//  cfg_    | cfg_valid/cfg_ready | cfg_data (16 bits) | frame interval write
//
// A first frame is taken and gives no result. Every other frame runs each
// axis through one shared radix-2 divider, 33 quotient bits one per cycle,
// and yields one result; a last frame yields two. Synchronous active-low
// reset clears the frame history and sets the interval to 1. A result waits
// in the output register while out_stall is high; the next frame is taken
// meanwhile.
// ---------------------------------------------------------------------------
`default_nettype none

module vector_finite_difference_velocity #(
  parameter int AXES         = vfdv_pkg::AXES_DEF,
  parameter int SAMPLE_WIDTH = vfdv_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire vfdv_pkg::in_item_t            in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output vfdv_pkg::out_item_t                out_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [vfdv_pkg::IV_W-1:0]     cfg_data
);

  localparam int FW       = vfdv_pkg::FIELD_W;
  localparam int NAX      = vfdv_pkg::NUM_AXES_MAX;
  localparam int AIW      = vfdv_pkg::AXIS_IDX_W;
  localparam int IVW      = vfdv_pkg::IV_W;
  localparam int DDW      = vfdv_pkg::DIVIDEND_W;
  localparam int DSW      = vfdv_pkg::DIVISOR_W;
  localparam int LANES    = (AXES < NAX) ? AXES : NAX;
  localparam int SAT_BITS = (SAMPLE_WIDTH < FW) ? SAMPLE_WIDTH : FW;

  localparam logic [AIW-1:0] LAST_AXIS = AIW'(LANES - 1);
  localparam logic [DDW-1:0] SAT_MAG   = DDW'(1) << (SAT_BITS - 1);
  localparam logic [FW-1:0]  VEL_MAX   = FW'((64'd1 << (SAT_BITS - 1)) - 64'd1);
  localparam logic [FW-1:0]  VEL_MIN   = ~VEL_MAX;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_PUSH
  } state_t;

  state_t                 state_r;
  logic [1:0]             phase_r;
  logic [IVW-1:0]         interval_r;
  logic signed [FW-1:0]   older_r [NAX];
  logic signed [FW-1:0]   newer_r [NAX];
  logic signed [FW-1:0]   cur_r   [NAX];
  logic [FW-1:0]          time_r;
  logic                   fin_r;
  logic                   res_idx_r;   // 0: central/forward, 1: backward
  logic [AIW-1:0]         axis_r;
  logic [FW-1:0]          vel_r   [NAX];
  logic                   sat_r;
  vfdv_pkg::out_item_t    out_r;
  logic                   out_valid_r;

  logic [IVW-1:0]         iv_eff;
  logic signed [FW-1:0]   op_a;
  logic signed [FW-1:0]   op_b;
  logic signed [DDW-1:0]  diff;
  logic                   neg;
  logic [DDW-1:0]         mag;
  logic [DSW-1:0]         den;
  logic                   div_start;
  logic                   div_done;
  logic [DDW-1:0]         quot;
  logic                   clip;
  logic [FW-1:0]          vel_axis;
  logic                   slot_free;
  logic                   in_take;

  function automatic logic signed [FW-1:0] pick_disp(vfdv_pkg::in_item_t it, int j);
    logic signed [FW-1:0] v;
    case (j)
      0:       v = it.disp_x;
      1:       v = it.disp_y;
      default: v = it.disp_z;
    endcase
    return v;
  endfunction

  assign iv_eff = (interval_r == '0) ? IVW'(1) : interval_r;

  // backward result of a two-held history reaches back to the newer frame
  assign op_a = cur_r[axis_r];
  assign op_b = (res_idx_r && phase_r != vfdv_pkg::PH_ONE) ? newer_r[axis_r]
                                                            : older_r[axis_r];
  assign diff = {op_a[FW-1], op_a} - {op_b[FW-1], op_b};
  assign neg  = diff[DDW-1];
  assign mag  = neg ? DDW'(-diff) : DDW'(diff);
  assign den  = (!res_idx_r && phase_r != vfdv_pkg::PH_ONE) ? {iv_eff, 1'b0}
                                                             : {1'b0, iv_eff};

  assign div_start = (state_r == ST_DIV_START);

  vfdv_div #(
    .DIVIDEND_W (DDW),
    .DIVISOR_W  (DSW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mag),
    .divisor  (den),
    .done     (div_done),
    .quotient (quot)
  );

  always_comb begin
    clip     = neg ? (quot > SAT_MAG) : (quot >= SAT_MAG);
    vel_axis = neg ? FW'(-quot[FW-1:0]) : quot[FW-1:0];
    if (clip) begin
      vel_axis = neg ? VEL_MIN : VEL_MAX;
    end
  end

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= vfdv_pkg::PH_EMPTY;
      interval_r  <= vfdv_pkg::IV_RESET;
      out_valid_r <= 1'b0;
      res_idx_r   <= 1'b0;
      axis_r      <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        interval_r <= cfg_data;
      end
      // drop a taken beat unless a new one is loaded below
      if (out_valid_r && !out_stall && state_r != ST_PUSH) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_take) begin
            if (phase_r == vfdv_pkg::PH_EMPTY) begin
              for (int j = 0; j < NAX; j++) begin
                older_r[j] <= pick_disp(in_data, j);
              end
              phase_r <= in_data.final_frame ? vfdv_pkg::PH_EMPTY : vfdv_pkg::PH_ONE;
            end else begin
              for (int j = 0; j < NAX; j++) begin
                cur_r[j] <= pick_disp(in_data, j);
                vel_r[j] <= '0;
              end
              time_r    <= in_data.frame_time;
              fin_r     <= in_data.final_frame;
              res_idx_r <= 1'b0;
              axis_r    <= '0;
              sat_r     <= 1'b0;
              state_r   <= ST_DIV_START;
            end
          end
        end

        ST_DIV_START: begin
          state_r <= ST_DIV_WAIT;
        end

        ST_DIV_WAIT: begin
          if (div_done) begin
            vel_r[axis_r] <= vel_axis;
            sat_r         <= sat_r | clip;
            if (axis_r == LAST_AXIS) begin
              state_r <= ST_PUSH;
            end else begin
              axis_r  <= axis_r + AIW'(1);
              state_r <= ST_DIV_START;
            end
          end
        end

        ST_PUSH: begin
          if (slot_free) begin
            out_r.vel_x     <= vel_r[0];
            out_r.vel_y     <= vel_r[1];
            out_r.vel_z     <= vel_r[2];
            out_r.stamp     <= res_idx_r ? time_r : time_r - FW'(iv_eff);
            out_r.saturated <= sat_r;
            out_r.run_end   <= res_idx_r;
            out_valid_r     <= 1'b1;
            if (!res_idx_r && fin_r) begin
              // queue the backward result of the last frame
              res_idx_r <= 1'b1;
              axis_r    <= '0;
              sat_r     <= 1'b0;
              for (int j = 0; j < NAX; j++) begin
                vel_r[j] <= '0;
              end
              state_r <= ST_DIV_START;
            end else begin
              for (int j = 0; j < NAX; j++) begin
                if (phase_r != vfdv_pkg::PH_ONE) begin
                  older_r[j] <= newer_r[j];
                end
                newer_r[j] <= cur_r[j];
              end
              phase_r <= fin_r ? vfdv_pkg::PH_EMPTY : vfdv_pkg::PH_TWO;
              state_r <= ST_IDLE;
            end
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

### rtl/core/vfdv_div.sv
// ---------------------------------------------------------------------------
// vfdv_div
// Radix-2 restoring divider, unsigned, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module vfdv_div #(
  parameter int DIVIDEND_W = vfdv_pkg::DIVIDEND_W,
  parameter int DIVISOR_W  = vfdv_pkg::DIVISOR_W
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  input  wire logic [DIVISOR_W-1:0]  divisor,
  output logic                       done,
  output logic [DIVIDEND_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVISOR_W-1:0]  rem_r;
  logic [DIVIDEND_W-1:0] quo_r;
  logic [DIVISOR_W-1:0]  den_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  busy_r;
  logic                  done_r;

  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  assign trial = {rem_r, quo_r[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = ~diff[DIVISOR_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (start) begin
        rem_r  <= '0;
        quo_r  <= dividend;
        den_r  <= divisor;
        cnt_r  <= CNT_W'(DIVIDEND_W);
        busy_r <= 1'b1;
        done_r <= 1'b0;
      end else if (busy_r) begin
        // shift in the next dividend bit, subtract when the divisor fits
        rem_r  <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        quo_r  <= {quo_r[DIVIDEND_W-2:0], fits};
        cnt_r  <= cnt_r - CNT_W'(1);
        done_r <= (cnt_r == CNT_W'(1));
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire
